[src/bsoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery SOC lookup filter package
// Shared widths, the discharge curve table, the sequencer states and the
// status bundle of the serial divide-by-five unit.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  localparam int MV_W               = 13;
  localparam int SOC_W              = 7;
  localparam int FILTER_FRAC_BITS_DEF = 16;

  localparam int CURVE_POINTS = 21;
  localparam int SEG_W        = 5;
  localparam int SPAN_W       = 9;
  localparam int DNUM_W       = 13;
  localparam int DDEN_W       = 10;

  localparam logic [MV_W-1:0]  MV_TOP    = 13'd4200;
  localparam logic [MV_W-1:0]  MV_BOTTOM = 13'd3270;
  localparam logic [SOC_W-1:0] SOC_FULL  = 7'd100;
  localparam logic [SOC_W-1:0] SOC_EMPTY = 7'd0;
  localparam logic [SOC_W-1:0] SOC_FIRST_BASE = 7'd95;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INTERP,
    ST_LOAD,
    ST_FILTER,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Discharge curve, in millivolts, from 100 % down to 0 % in 5 % steps.
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] mv;
    unique case (idx)
      5'd0:    mv = 13'd4200;
      5'd1:    mv = 13'd4150;
      5'd2:    mv = 13'd4110;
      5'd3:    mv = 13'd4080;
      5'd4:    mv = 13'd4020;
      5'd5:    mv = 13'd3980;
      5'd6:    mv = 13'd3950;
      5'd7:    mv = 13'd3910;
      5'd8:    mv = 13'd3870;
      5'd9:    mv = 13'd3830;
      5'd10:   mv = 13'd3820;
      5'd11:   mv = 13'd3810;
      5'd12:   mv = 13'd3800;
      5'd13:   mv = 13'd3770;
      5'd14:   mv = 13'd3760;
      5'd15:   mv = 13'd3750;
      5'd16:   mv = 13'd3730;
      5'd17:   mv = 13'd3710;
      5'd18:   mv = 13'd3690;
      5'd19:   mv = 13'd3670;
      default: mv = 13'd3270;
    endcase
    return mv;
  endfunction

endpackage

[src/bsoc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voltage sample channel
// Valid/ready channel carrying one battery voltage sample per beat.
// ----------------------------------------------------------------------------
interface bsoc_in_if;
  logic                      valid;
  logic                      ready;
  logic [bsoc_pkg::MV_W-1:0] voltage_mv;

  modport source (output valid, output voltage_mv, input ready);
  modport sink   (input valid, input voltage_mv, output ready);
endinterface

[src/bsoc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// State of charge result channel
// Valid/ready channel carrying the instant and filtered percentages.
// ----------------------------------------------------------------------------
interface bsoc_out_if;
  logic                       valid;
  logic                       ready;
  logic [bsoc_pkg::SOC_W-1:0] soc_instant;
  logic [bsoc_pkg::SOC_W-1:0] soc_filtered;

  modport source (output valid, output soc_instant, output soc_filtered, input ready);
  modport sink   (input valid, input soc_instant, input soc_filtered, output ready);
endinterface

[src/bsoc_div5.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divide by five
// Restoring division by the constant five, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsoc_div5 #(
  parameter int NUM_W = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  output logic [NUM_W-1:0]      quo,
  output bsoc_pkg::div_stat_t   stat
);
  import bsoc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh;
  logic [2:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [3:0]       trial;
  logic             qbit;

  // Bring down the next numerator bit and try to take five away.
  always_comb begin
    trial = {rem, sh[NUM_W-1]};
    qbit  = (trial >= 4'd5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      rem <= 3'd0;
    end else if (busy) begin
      sh  <= {sh[NUM_W-2:0], qbit};
      rem <= qbit ? 3'(trial - 4'd5) : trial[2:0];
    end
  end

  assign quo  = sh;
  assign stat = '{busy: busy, done: done};

endmodule

[src/battery_soc_lookup_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery state of charge lookup with exponential filter
// Maps each voltage sample to a percentage on a 21-point discharge curve and
// smooths it with new = (4*old + instant)/5 held in fixed point.
// ----------------------------------------------------------------------------
// Usage: every beat on the sample channel carries one voltage in millivolts;
// every sample yields exactly one beat on the result channel with the
// interpolated percentage and the filtered percentage, in sample order.
// The block works on one sample at a time. A sample is taken only while the
// sequencer is idle. The curve is searched one segment per cycle, the
// interpolation quotient is found by a three-step restoring divide, and
// the filter update runs through a bit-serial divide by five of
// FILTER_FRAC_BITS + 9 bits. The quickest sample is a voltage beyond
// either end of the curve arriving before the filter is seeded; the
// slowest are dominated by the serial filter divide and the curve search.
// Results sit in an output register: the next sample is taken while a result
// still waits, and a new result waits in the last sequencer state until the
// register has been drained, so a stalled receiver loses nothing.
// Reset clears the filter level and its seeded flag and empties the output
// register; the first sample after reset seeds the filter directly.
// ----------------------------------------------------------------------------
module battery_soc_lookup_filter_core #(
  parameter int FILTER_FRAC_BITS = bsoc_pkg::FILTER_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  bsoc_in_if.sink     sample,
  bsoc_out_if.source  result
);
  import bsoc_pkg::*;

  // Filter level is Q7.FILTER_FRAC_BITS; the update numerator needs two
  // more bits for the factor of four.
  localparam int LVL_W = SOC_W + FILTER_FRAC_BITS;
  localparam int NUM_W = LVL_W + 2;

  state_t state;
  state_t state_next;

  logic [MV_W-1:0]   mv;
  logic [SEG_W-1:0]  seg;
  logic [SOC_W-1:0]  soc;
  logic [DNUM_W-1:0] dnum;
  logic [DDEN_W-1:0] dden;
  logic [1:0]        dcnt;
  logic [LVL_W-1:0]  level;
  logic              primed;

  logic [SOC_W-1:0]  res_instant;
  logic [SOC_W-1:0]  res_filtered;
  logic              res_valid;

  // Curve search: the first segment whose lower point is at or below the
  // sample is the one that holds it.
  logic [MV_W-1:0]   seg_hi;
  logic [MV_W-1:0]   seg_lo;
  logic              seg_hit;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] offset;
  logic [DNUM_W-1:0] interp_num;
  logic [SOC_W-1:0]  seg_base;

  always_comb begin
    seg_hi     = curve_mv(seg);
    seg_lo     = curve_mv(SEG_W'(seg + 1'b1));
    seg_hit    = (mv >= seg_lo);
    span       = SPAN_W'(seg_hi - seg_lo);
    offset     = SPAN_W'(mv - seg_lo);
    // (mv - lo) * 10 + span, the rounding term for the half-up divide.
    interp_num = DNUM_W'({offset, 3'b000}) + DNUM_W'({offset, 1'b0}) + DNUM_W'(span);
    // 100 - 5 * (seg + 1)
    seg_base   = SOC_FIRST_BASE - (SOC_W'({seg, 2'b00}) + SOC_W'(seg));
  end

  // Interpolation quotient is at most five, so three restoring steps do.
  logic [DNUM_W-1:0] ddiv_shifted;
  logic              ddiv_take;

  always_comb begin
    ddiv_shifted = DNUM_W'(dden) << dcnt;
    ddiv_take    = (dnum >= ddiv_shifted);
  end

  // Filter update divide: (4*old + instant + rounding) / 5.
  logic [NUM_W-1:0] filt_num;
  logic [NUM_W-1:0] filt_quo;
  logic             div_start;
  div_stat_t        div_stat;
  logic [LVL_W-1:0] soc_scaled;

  assign soc_scaled = {soc, FILTER_FRAC_BITS'(0)};
  assign filt_num   = {level, 2'b00} + NUM_W'(soc_scaled) + NUM_W'(2);

  bsoc_div5 #(
    .NUM_W (NUM_W)
  ) u_div5 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (filt_num),
    .quo   (filt_quo),
    .stat  (div_stat)
  );

  // Filtered percentage: level rounded half up to an integer.
  logic [LVL_W:0]   level_round;
  logic [SOC_W-1:0] filt_pct;

  assign level_round = {1'b0, level} + ((LVL_W + 1)'(1) << (FILTER_FRAC_BITS - 1));
  assign filt_pct    = level_round[FILTER_FRAC_BITS +: SOC_W];

  logic out_free;
  assign out_free = !res_valid || result.ready;

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    div_start    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          if (sample.voltage_mv >= MV_TOP || sample.voltage_mv <= MV_BOTTOM) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (seg_hit) begin
          state_next = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (dcnt == 2'd0) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (primed) begin
          div_start  = 1'b1;
          state_next = ST_FILTER;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_FILTER: begin
        if (div_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      level     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result loads the output register as the old one leaves.
      if (state == ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (!primed) begin
            level  <= soc_scaled;
            primed <= 1'b1;
          end
        end
        ST_FILTER: begin
          if (div_stat.done) begin
            level <= filt_quo[LVL_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mv  <= sample.voltage_mv;
        seg <= '0;
        soc <= (sample.voltage_mv >= MV_TOP) ? SOC_FULL : SOC_EMPTY;
      end
      ST_SCAN: begin
        if (seg_hit) begin
          dnum <= interp_num;
          dden <= {span, 1'b0};
          dcnt <= 2'd2;
          soc  <= seg_base;
        end else begin
          seg <= seg + 1'b1;
        end
      end
      ST_INTERP: begin
        if (ddiv_take) begin
          dnum <= dnum - ddiv_shifted;
          soc  <= soc + (SOC_W'(1) << dcnt);
        end
        dcnt <= dcnt - 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          res_instant  <= soc;
          res_filtered <= filt_pct;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid        = res_valid;
  assign result.soc_instant  = res_instant;
  assign result.soc_filtered = res_filtered;

endmodule
